[src/kvct_pkg.sv]
// Shared types and constants for the key/value configuration tokenizer.
// No dependencies; imported by key_value_config_tokenizer.
`default_nettype none

package kvct_pkg;

  localparam int ITEMS_MAX_DEF  = 32;
  localparam int HOLD_DEPTH_DEF = 16;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 6;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  typedef enum logic [KIND_W-1:0] {
    KIND_NAME  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ITEM  = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_NAME    = 2'd0,
    MODE_VALUE   = 2'd1,
    MODE_COMMENT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_OVF   = 2'd1,
    ST_FLUSH = 2'd2,
    ST_BYTE  = 2'd3
  } state_t;

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

`default_nettype wire

[src/key_value_config_tokenizer.sv]
// Key/value configuration tokenizer: splits name=value text into name bytes,
// value bytes, item marks and an end-of-text count. Depends on kvct_pkg.
//
//   channel | dir | tdata                                   | tuser / tlast
//   in_     | in  | [7:0] text_byte                         | -
//   out_    | out | [7:0] out_byte, [13:8] item_number, pad | tuser[1:0] token_kind,
//           |     |                                         | tuser[2] trim_overflow,
//           |     |                                         | tlast run_last
//
// Most bytes are handled in ST_IDLE; a value byte releasing held whitespace goes
// through ST_FLUSH then ST_BYTE, a hold-buffer overflow through ST_OVF. Held bytes
// sit in a HOLD_DEPTH-entry ring memory read one entry per cycle while the output is free.
// Reset (rst_n low, synchronous) clears control state; the ring needs no clear.
// A stalled output register holds and stops further input transfers.
`default_nettype none

module key_value_config_tokenizer
  import kvct_pkg::*;
#(
  parameter int ITEMS_MAX  = ITEMS_MAX_DEF,
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [13:8] item_number, [15:14] zero
  output logic [2:0]       out_tuser,  // [1:0] token_kind, [2] trim_overflow
  output logic             out_tlast   // run_last
);

  localparam int PW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [PW-1:0]      HEAD_LAST = PW'(HOLD_DEPTH - 1);
  localparam logic [CW-1:0]      CNT_FULL  = CW'(HOLD_DEPTH);
  localparam logic [SW-1:0]      SUM_WRAP  = SW'(HOLD_DEPTH);
  localparam logic [INDEX_W:0]   IDX_LIMIT = (INDEX_W+1)'(ITEMS_MAX);
  localparam logic [INDEX_W-1:0] IDX_MAX   = INDEX_W'(ITEMS_MAX);

  // Control state
  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic                started_r, started_nxt;
  logic [INDEX_W-1:0]  index_r, index_nxt;
  logic                full_r, full_nxt;
  logic [PW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [BYTE_W-1:0]   cur_byte_r, cur_byte_nxt;

  // Output register
  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic [INDEX_W-1:0]  out_num_r;
  logic                out_last_r;
  logic                out_ovf_r;

  logic                load;
  kind_t               ld_kind;
  logic [BYTE_W-1:0]   ld_byte;
  logic [INDEX_W-1:0]  ld_num;
  logic                ld_last;
  logic                ld_ovf;

  // Hold ring memory
  logic [BYTE_W-1:0]   hold_mem [HOLD_DEPTH];
  logic [BYTE_W-1:0]   rdata_r;
  logic                mem_we;
  logic [PW-1:0]       mem_waddr;
  logic [BYTE_W-1:0]   mem_wdata;

  logic                slot_free;
  logic                in_xfer;
  logic [BYTE_W-1:0]   c;
  logic [PW-1:0]       head_inc;
  logic [SW-1:0]       tail_sum;
  logic [PW-1:0]       tail;
  logic [INDEX_W:0]    index_inc;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign c         = in_tdata;

  assign head_inc  = (head_r == HEAD_LAST) ? '0 : head_r + PW'(1);
  assign tail_sum  = SW'(head_r) + SW'(count_r);
  assign tail      = (tail_sum >= SUM_WRAP) ? PW'(tail_sum - SUM_WRAP) : PW'(tail_sum);
  assign index_inc = {1'b0, index_r} + (INDEX_W+1)'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && c != CH_NUL && !full_r && mode_r == MODE_VALUE
            && c != CH_LF && c != CH_HASH) begin
          if (is_blank(c)) begin
            if (started_r && count_r == CNT_FULL) state_nxt = ST_OVF;
          end else if (count_r != '0) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_OVF: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_FLUSH: begin
        if (slot_free && count_r == CW'(1)) state_nxt = ST_BYTE;
      end
      ST_BYTE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    mode_nxt     = mode_r;
    started_nxt  = started_r;
    index_nxt    = index_r;
    full_nxt     = full_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    cur_byte_nxt = cur_byte_r;
    load         = 1'b0;
    ld_kind      = KIND_NAME;
    ld_byte      = '0;
    ld_num       = index_r;
    ld_last      = 1'b1;
    ld_ovf       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = tail;
    mem_wdata    = c;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cur_byte_nxt = c;
          if (c == CH_NUL) begin
            load        = 1'b1;
            ld_kind     = KIND_END;
            ld_num      = full_r ? IDX_MAX : index_inc[INDEX_W-1:0];
            mode_nxt    = MODE_NAME;
            started_nxt = 1'b0;
            index_nxt   = '0;
            full_nxt    = 1'b0;
            count_nxt   = '0;
          end else if (full_r) begin
            // drop everything until end of text
          end else begin
            case (mode_r)
              MODE_NAME: begin
                if (c == CH_EQ) begin
                  mode_nxt    = MODE_VALUE;
                  started_nxt = 1'b0;
                  count_nxt   = '0;
                end else if (c == CH_HASH) begin
                  mode_nxt = MODE_COMMENT;
                end else if (!is_blank(c)) begin
                  load        = 1'b1;
                  ld_kind     = KIND_NAME;
                  ld_byte     = c;
                  started_nxt = 1'b1;
                end
              end
              MODE_VALUE: begin
                if (c == CH_LF || c == CH_HASH) begin
                  load        = 1'b1;
                  ld_kind     = KIND_ITEM;
                  count_nxt   = '0;
                  started_nxt = 1'b0;
                  mode_nxt    = (c == CH_LF) ? MODE_NAME : MODE_COMMENT;
                  index_nxt   = index_inc[INDEX_W-1:0];
                  if (index_inc >= IDX_LIMIT) full_nxt = 1'b1;
                end else if (is_blank(c)) begin
                  // hold inner whitespace; a full ring first releases its oldest
                  if (started_r && count_r != CNT_FULL) begin
                    mem_we    = 1'b1;
                    count_nxt = count_r + CW'(1);
                  end
                end else if (count_r == '0) begin
                  load        = 1'b1;
                  ld_kind     = KIND_VALUE;
                  ld_byte     = c;
                  started_nxt = 1'b1;
                end else begin
                  started_nxt = 1'b1;
                end
              end
              MODE_COMMENT: begin
                if (c == CH_LF) begin
                  mode_nxt    = MODE_NAME;
                  started_nxt = 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_OVF: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_kind   = KIND_VALUE;
          ld_byte   = rdata_r;
          ld_ovf    = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = head_r;
          mem_wdata = cur_byte_r;
          head_nxt  = head_inc;
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_kind   = KIND_VALUE;
          ld_byte   = rdata_r;
          ld_last   = 1'b0;
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
        end
      end
      ST_BYTE: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_kind = KIND_VALUE;
          ld_byte = cur_byte_r;
        end
      end
      default: ;
    endcase
  end

  // Ring memory: read data follows the next head pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hold_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= hold_mem[head_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_NAME;
      started_r   <= 1'b0;
      index_r     <= '0;
      full_r      <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      started_r <= started_nxt;
      index_r   <= index_nxt;
      full_r    <= full_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_byte_r <= cur_byte_nxt;
    if (load) begin
      out_kind_r <= ld_kind;
      out_byte_r <= ld_byte;
      out_num_r  <= ld_num;
      out_last_r <= ld_last;
      out_ovf_r  <= ld_ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_num_r, out_byte_r};
  assign out_tuser  = {out_ovf_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
